// ===== sv/i2a_pkg.sv =====
`default_nettype none

package i2a_pkg;

  // field widths
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned NUM_DEC_DIGITS = 20;
  localparam int unsigned NUM_HEX_DIGITS = 16;

  // command codes
  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_PTR = 2'd2;
  localparam logic [1:0] CMD_BAD = 2'd3;

  // ascii characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef logic [3:0] digit_t;

  // control of the bcd cell row
  typedef struct packed {
    logic clr;
    logic shift;
    logic serial_bit;
  } chain_ctrl_t;

  // digit value to lower-case ascii
  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2a_bcd_cell.sv =====
`default_nettype none

module i2a_bcd_cell
  import i2a_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   clr_i,
  input  wire logic   shift_i,
  input  wire logic   bit_i,
  output digit_t      digit_o
);

  digit_t digit_q, digit_d;
  digit_t adj;

  // add three when the digit would overflow on doubling
  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    digit_d = digit_q;
    if (clr_i) begin
      digit_d = '0;
    end else if (shift_i) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ===== sv/i2a_bcd_chain.sv =====
`default_nettype none

module i2a_bcd_chain
  import i2a_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire chain_ctrl_t ctrl_i,
  output digit_t           digits_o [NUM_DEC_DIGITS]
);

  logic carry [NUM_DEC_DIGITS];

  // each cell takes the carry of its lower neighbour, the first one the binary bit
  for (genvar i = 0; i < NUM_DEC_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign carry[i] = ctrl_i.serial_bit;
    end else begin : g_next
      assign carry[i] = (digits_o[i-1] >= 4'd5);
    end

    i2a_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (ctrl_i.clr),
      .shift_i (ctrl_i.shift),
      .bit_i   (carry[i]),
      .digit_o (digits_o[i])
    );
  end

endmodule

`default_nettype wire

// ===== sv/integer_to_ascii_formatter_top.sv =====
`default_nettype none

// channel | handshake              | payload
// --------+------------------------+-------------------------------------------
// in      | in_valid_i, in_ready_o | command_i, value_i, zero_pad_i,
//         |                        | pad_width_i, room_i
// out     | out_valid_o, out_ready_i | character_o, last_o, error_o
//
// decimal items are shifted through the bcd cell row (one bit per cycle) in
// ST_CONV, other items skip it; ST_LEN then sizes the field, and ST_EMIT
// sends one character a cycle unless stalled; an error item sends one nul.
// the next item is taken once the last beat sits in the output register.
// a stalled output holds the character sequencer; reset is asynchronous.

module integer_to_ascii_formatter_top
  import i2a_pkg::*;
#(
  parameter int unsigned MAX_PAD_WIDTH = 62
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   command_i,
  input  wire logic [63:0]  value_i,
  input  wire logic         zero_pad_i,
  input  wire logic [5:0]   pad_width_i,
  input  wire logic [7:0]   room_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        character_o,
  output logic              last_o,
  output logic              error_o
);

  localparam logic [5:0] MaxPad = 6'(MAX_PAD_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEN,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q, cmd_d;
  logic              neg_q, neg_d;
  logic              zp_q, zp_d;
  logic [5:0]        pw_q, pw_d;
  logic [7:0]        room_q, room_d;
  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [6:0]        total_q, total_d;
  logic [6:0]        b1_q, b1_d;
  logic [6:0]        b2_q, b2_d;
  logic [6:0]        pfx_q, pfx_d;
  logic [6:0]        pos_q, pos_d;
  logic [4:0]        dig_idx_q, dig_idx_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic              error_q, error_d;

  chain_ctrl_t       chain_ctrl;
  digit_t            bcd [NUM_DEC_DIGITS];

  logic [4:0]        ndig;
  logic [1:0]        plen;
  logic [6:0]        total;
  logic [6:0]        npad;
  logic [6:0]        span;
  digit_t            cur_nib;
  logic [7:0]        pfx_char;
  logic [7:0]        seg_char;
  logic              load;

  i2a_bcd_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (chain_ctrl),
    .digits_o (bcd)
  );

  // significant digit count, at least one
  always_comb begin
    ndig = 5'd1;
    if (cmd_q == CMD_DEC) begin
      for (int i = 1; i < NUM_DEC_DIGITS; i++) begin
        if (bcd[i] != '0) ndig = 5'(i + 1);
      end
    end else begin
      for (int i = 1; i < NUM_HEX_DIGITS; i++) begin
        if (mag_q[4*i +: 4] != '0) ndig = 5'(i + 1);
      end
    end
  end

  // field length and padding
  always_comb begin
    plen = neg_q ? 2'd1 : ((cmd_q == CMD_PTR) ? 2'd2 : 2'd0);
    span = {2'd0, ndig} + {5'd0, plen};
    if (cmd_q == CMD_PTR) begin
      total = 7'd2 + ((ndig > pw_q[4:0] && pw_q[5] == 1'b0) ? {2'd0, ndig} : {1'b0, pw_q});
    end else begin
      total = (span > {1'b0, pw_q}) ? span : {1'b0, pw_q};
    end
    npad = total - span;
  end

  // current character
  always_comb begin
    if (cmd_q == CMD_DEC) begin
      cur_nib = bcd[dig_idx_q];
    end else begin
      cur_nib = mag_q[{dig_idx_q[3:0], 2'b00} +: 4];
    end
    if (cmd_q == CMD_PTR) begin
      pfx_char = (pos_q == pfx_q) ? CH_ZERO : CH_X;
    end else begin
      pfx_char = CH_MINUS;
    end
    if (pos_q < b1_q) begin
      seg_char = zp_q ? pfx_char : CH_SPACE;
    end else if (pos_q < b2_q) begin
      seg_char = zp_q ? CH_ZERO : pfx_char;
    end else begin
      seg_char = digit_char(cur_nib);
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    neg_d       = neg_q;
    zp_d        = zp_q;
    pw_d        = pw_q;
    room_d      = room_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    pfx_d       = pfx_q;
    pos_d       = pos_q;
    dig_idx_d   = dig_idx_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    error_d     = error_q;

    in_ready_o       = (state_q == ST_IDLE);
    chain_ctrl.clr        = 1'b0;
    chain_ctrl.shift      = (state_q == ST_CONV);
    chain_ctrl.serial_bit = mag_q[VALUE_W-1];
    load             = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          chain_ctrl.clr = 1'b1;
          cmd_d  = command_i;
          neg_d  = (command_i == CMD_DEC) && value_i[VALUE_W-1];
          mag_d  = ((command_i == CMD_DEC) && value_i[VALUE_W-1]) ? (~value_i + 64'd1)
                                                                  : value_i;
          zp_d   = zero_pad_i;
          pw_d   = (pad_width_i > MaxPad) ? MaxPad : pad_width_i;
          room_d = room_i;
          cnt_d  = '0;
          state_d = (command_i == CMD_DEC) ? ST_CONV : ST_LEN;
        end
      end
      ST_CONV: begin
        mag_d = {mag_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (&cnt_q) state_d = ST_LEN;
      end
      ST_LEN: begin
        total_d   = total;
        err_d     = (cmd_q == CMD_BAD) || ({1'b0, total} > room_q);
        b1_d      = zp_q ? {5'd0, plen} : npad;
        b2_d      = npad + {5'd0, plen};
        pfx_d     = zp_q ? 7'd0 : npad;
        pos_d     = '0;
        dig_idx_d = ndig - 5'd1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            char_d  = CH_NUL;
            last_d  = 1'b1;
            error_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            char_d  = seg_char;
            last_d  = (pos_q == total_q - 7'd1);
            error_d = 1'b0;
            pos_d   = pos_q + 7'd1;
            if (pos_q >= b2_q) dig_idx_d = dig_idx_q - 5'd1;
            if (pos_q == total_q - 7'd1) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_DEC;
      neg_q       <= 1'b0;
      zp_q        <= 1'b0;
      pw_q        <= '0;
      room_q      <= '0;
      mag_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      pfx_q       <= '0;
      pos_q       <= '0;
      dig_idx_q   <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      error_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      neg_q       <= neg_d;
      zp_q        <= zp_d;
      pw_q        <= pw_d;
      room_q      <= room_d;
      mag_q       <= mag_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      pfx_q       <= pfx_d;
      pos_q       <= pos_d;
      dig_idx_q   <= dig_idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      error_q     <= error_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

endmodule

`default_nettype wire
